>>> sv/tlwms_pkg.sv
// ---------------------------------------------------------------------------
// tlwms_pkg
// Shared widths, limits and register indexes of the torus line window max sum
// block.
// ---------------------------------------------------------------------------
package tlwms_pkg;

  // Field widths
  localparam int CELL_W = 16;  // signed grid element
  localparam int CFG_W  = 7;   // each configuration register
  localparam int OUT_W  = 21;  // unsigned result

  // Segment accumulator: 16-bit cells, up to 127 terms, plus sign
  localparam int ACC_W  = CELL_W + CFG_W + 1;

  // Default store side
  localparam int MAX_SIDE_DEF = 64;

  // Register reset values
  localparam logic [CFG_W-1:0] GRID_SIZE_RST  = 7'd64;
  localparam logic [CFG_W-1:0] RUN_LENGTH_RST = 7'd1;

  // Result ceiling
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_RUN_LENGTH = 1'd1;

endpackage

>>> sv/torus_line_window_max_sum.sv
// ---------------------------------------------------------------------------
// torus_line_window_max_sum
// Stores an n by n signed grid and reports the best run_length segment sum
// over four directions on a torus.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_cell_value): grid cells in row-major
//   order, one request per cycle while loading. Each request is written to the
//   grid RAM. The n*n-th request starts the sweep; in_ready stays low until the
//   result has been placed in the output register.
//   Sweep: for each start cell and each direction (up-right, right,
//   down-right, down) the segment is read one cell per cycle through the single
//   RAM read port; then the pipeline drains and the result is handed off after
//   the last cell. A run length of zero skips the sweep and yields zero.
//   Output channel (out_valid/out_ready/out_max_sum): one request per grid,
//   held in an output register. Loading of the next grid goes on while it
//   waits; a stalled receiver only holds the block once the next sweep ends.
//   Configuration (cfg_we/cfg_index/cfg_data): grid_size and run_length, to be
//   written by the user only while loading with no sweep running; the block
//   itself does not enforce this. A side change mid-load is legal.
//   Reset (rst_n low, synchronous): registers return to grid_size 64 and
//   run_length 1, the load count clears, no result is pending. RAM contents are
//   not cleared.
// ---------------------------------------------------------------------------
module torus_line_window_max_sum #(
  parameter int MAX_SIDE = tlwms_pkg::MAX_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [tlwms_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [tlwms_pkg::CFG_W-1:0]       cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tlwms_pkg::CELL_W-1:0] in_cell_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tlwms_pkg::OUT_W-1:0]       out_max_sum
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int CFG_W  = tlwms_pkg::CFG_W;
  localparam int CELL_W = tlwms_pkg::CELL_W;
  localparam int ACC_W  = tlwms_pkg::ACC_W;
  localparam int OUT_W  = tlwms_pkg::OUT_W;

  typedef enum logic [1:0] {ST_LOAD, ST_SWEEP, ST_DRAIN, ST_FINISH} state_t;
  typedef enum logic [1:0] {DIR_UP_RIGHT, DIR_RIGHT, DIR_DOWN_RIGHT, DIR_DOWN} dir_t;

  // registers
  state_t             state_r,      state_nxt;
  logic [CFG_W-1:0]   grid_size_r,  grid_size_nxt;
  logic [CFG_W-1:0]   run_length_r, run_length_nxt;
  logic [CNT_W-1:0]   load_count_r, load_count_nxt;
  logic [IDX_W-1:0]   i_r,          i_nxt;
  logic [IDX_W-1:0]   j_r,          j_nxt;
  logic [IDX_W-1:0]   row_r,        row_nxt;
  logic [IDX_W-1:0]   col_r,        col_nxt;
  logic [CFG_W-1:0]   l_r,          l_nxt;
  dir_t               dir_r,        dir_nxt;
  logic               rd_valid_r,   rd_valid_nxt;
  logic               rd_first_r,   rd_first_nxt;
  logic               rd_last_r,    rd_last_nxt;
  logic signed [ACC_W-1:0] acc_r,   acc_nxt;
  logic signed [ACC_W-1:0] best_r,  best_nxt;
  logic               out_valid_r,  out_valid_nxt;
  logic [OUT_W-1:0]   out_max_sum_r, out_max_sum_nxt;

  // combinational helpers
  logic [SIDE_W-1:0]  n_use;
  logic [IDX_W-1:0]   n_m1;
  logic [CNT_W-1:0]   n_sq;
  logic [CNT_W-1:0]   load_inc;
  logic               in_fire;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;
  logic [IDX_W-1:0]   row_dec, row_inc, col_inc, i_inc, j_inc;
  logic               seg_last;
  logic signed [ACC_W-1:0] cell_ext;
  logic signed [ACC_W-1:0] seg_sum;
  logic [OUT_W-1:0]   best_sat;

  // Side in use: zero acts as one, large values clamp to the store side
  always_comb begin
    if (grid_size_r == '0) begin
      n_use = SIDE_W'(1);
    end else if (int'(grid_size_r) > MAX_SIDE) begin
      n_use = SIDE_W'(MAX_SIDE);
    end else begin
      n_use = SIDE_W'(grid_size_r);
    end
  end

  assign n_m1     = IDX_W'(n_use - SIDE_W'(1));
  assign n_sq     = CNT_W'(CNT_W'(n_use) * CNT_W'(n_use));
  assign load_inc = load_count_r + CNT_W'(1);

  assign in_ready = (state_r == ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign ram_we   = in_fire && (int'(load_count_r) < DEPTH);

  // Torus steps
  assign row_dec = (row_r == '0)   ? n_m1 : row_r - IDX_W'(1);
  assign row_inc = (row_r == n_m1) ? '0   : row_r + IDX_W'(1);
  assign col_inc = (col_r == n_m1) ? '0   : col_r + IDX_W'(1);
  assign i_inc   = i_r + IDX_W'(1);
  assign j_inc   = j_r + IDX_W'(1);

  assign seg_last  = (l_r == run_length_r - CFG_W'(1));
  assign ram_raddr = AW'(AW'(row_r) * AW'(n_use) + AW'(col_r));

  tlwms_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_count_r[AW-1:0]),
    .wdata (in_cell_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Segment accumulation on returning read data
  assign cell_ext = {{(ACC_W - CELL_W){ram_rdata[CELL_W-1]}}, ram_rdata};
  assign seg_sum  = (rd_first_r ? '0 : acc_r) + cell_ext;

  // best is never negative; clamp the upper bits
  assign best_sat = (best_r[ACC_W-1:OUT_W] != '0) ? tlwms_pkg::OUT_MAX
                                                  : best_r[OUT_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    grid_size_nxt   = grid_size_r;
    run_length_nxt  = run_length_r;
    load_count_nxt  = load_count_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    l_nxt           = l_r;
    dir_nxt         = dir_r;
    rd_valid_nxt    = 1'b0;
    rd_first_nxt    = rd_first_r;
    rd_last_nxt     = rd_last_r;
    acc_nxt         = acc_r;
    best_nxt        = best_r;
    out_valid_nxt   = out_valid_r;
    out_max_sum_nxt = out_max_sum_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        tlwms_pkg::REG_GRID_SIZE:  grid_size_nxt  = cfg_data;
        tlwms_pkg::REG_RUN_LENGTH: run_length_nxt = cfg_data;
        default: ;
      endcase
    end

    if (rd_valid_r) begin
      acc_nxt = seg_sum;
      if (rd_last_r && (seg_sum > best_r)) begin
        best_nxt = seg_sum;
      end
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (load_inc >= n_sq) begin
            load_count_nxt = '0;
            best_nxt       = '0;
            i_nxt          = '0;
            j_nxt          = '0;
            row_nxt        = '0;
            col_nxt        = '0;
            l_nxt          = '0;
            dir_nxt        = DIR_UP_RIGHT;
            state_nxt      = (run_length_r == '0) ? ST_FINISH : ST_SWEEP;
          end else begin
            load_count_nxt = load_inc;
          end
        end
      end

      ST_SWEEP: begin
        // one RAM read per cycle; tags follow the data
        rd_valid_nxt = 1'b1;
        rd_first_nxt = (l_r == '0);
        rd_last_nxt  = seg_last;
        if (!seg_last) begin
          l_nxt = l_r + CFG_W'(1);
          unique case (dir_r)
            DIR_UP_RIGHT: begin
              row_nxt = row_dec;
              col_nxt = col_inc;
            end
            DIR_RIGHT: begin
              col_nxt = col_inc;
            end
            DIR_DOWN_RIGHT: begin
              row_nxt = row_inc;
              col_nxt = col_inc;
            end
            DIR_DOWN: begin
              row_nxt = row_inc;
            end
            default: ;
          endcase
        end else begin
          l_nxt = '0;
          if (dir_r != DIR_DOWN) begin
            dir_nxt = dir_t'(dir_r + 2'd1);
            row_nxt = i_r;
            col_nxt = j_r;
          end else begin
            dir_nxt = DIR_UP_RIGHT;
            if (j_r != n_m1) begin
              j_nxt   = j_inc;
              row_nxt = i_r;
              col_nxt = j_inc;
            end else begin
              j_nxt   = '0;
              col_nxt = '0;
              if (i_r != n_m1) begin
                i_nxt   = i_inc;
                row_nxt = i_inc;
              end else begin
                state_nxt = ST_DRAIN;
              end
            end
          end
        end
      end

      ST_DRAIN: begin
        // last read data lands this cycle
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_max_sum_nxt = best_sat;
          state_nxt       = ST_LOAD;
        end
      end

      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      grid_size_r  <= tlwms_pkg::GRID_SIZE_RST;
      run_length_r <= tlwms_pkg::RUN_LENGTH_RST;
      load_count_r <= '0;
      rd_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      dir_r        <= DIR_UP_RIGHT;
    end else begin
      state_r      <= state_nxt;
      grid_size_r  <= grid_size_nxt;
      run_length_r <= run_length_nxt;
      load_count_r <= load_count_nxt;
      rd_valid_r   <= rd_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      dir_r        <= dir_nxt;
    end
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    row_r         <= row_nxt;
    col_r         <= col_nxt;
    l_r           <= l_nxt;
    rd_first_r    <= rd_first_nxt;
    rd_last_r     <= rd_last_nxt;
    acc_r         <= acc_nxt;
    best_r        <= best_nxt;
    out_max_sum_r <= out_max_sum_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_max_sum = out_max_sum_r;

endmodule

>>> sv/tlwms_ram.sv
// ---------------------------------------------------------------------------
// tlwms_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ---------------------------------------------------------------------------
module tlwms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
